// ===== hdl/auf_pkg.sv =====
// ----------------------------------------------------------------------------
// auf_pkg
// Shared types and constants for the advertising record filter.
// ----------------------------------------------------------------------------
package auf_pkg;

    localparam int unsigned NameMax = 16;

    typedef enum logic [1:0] {
        CFG_TARGET_UUID = 2'd0,
        CFG_NAME_LOW    = 2'd1,
        CFG_NAME_HIGH   = 2'd2,
        CFG_NAME_LENGTH = 2'd3
    } t_cfg_index;

    localparam logic [7:0] TYPE_UUID_A = 8'h02;
    localparam logic [7:0] TYPE_UUID_B = 8'h03;
    localparam logic [7:0] TYPE_UUID_C = 8'h05;
    localparam logic [7:0] TYPE_UUID_D = 8'h07;
    localparam logic [7:0] TYPE_SVC_DATA = 8'h16;
    localparam logic [15:0] UUID_RESET = 16'hABCD;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       in_record;
        logic [7:0] pos;
        logic       last_byte;
        logic [8:0] room;
    } t_item;

    function automatic logic is_uuid_type(input logic [7:0] t);
        is_uuid_type = (t == TYPE_UUID_A) || (t == TYPE_UUID_B) || (t == TYPE_UUID_C)
            || (t == TYPE_UUID_D) || (t == TYPE_SVC_DATA);
    endfunction

endpackage

// ===== hdl/auf_front.sv =====
// ----------------------------------------------------------------------------
// auf_front
// Tracks byte position, classifies each item against the record length and
// pushes it into a two-entry queue.
// ----------------------------------------------------------------------------
module auf_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [7:0]         i_data_byte,
    input  logic [7:0]         i_record_len,
    input  logic               i_last_byte,
    output logic               o_q_valid,
    input  logic               i_q_ready,
    output auf_pkg::t_item     o_q_item
);
    logic [7:0]     r_pos;
    auf_pkg::t_item r_q [2];
    logic           r_rd;
    logic           r_wr;
    logic [1:0]     r_cnt;
    logic           w_push;
    logic           w_pop;
    auf_pkg::t_item w_item;

    assign o_ready   = (r_cnt != 2'd2);
    assign w_push    = i_valid && o_ready;
    assign o_q_valid = (r_cnt != 2'd0);
    assign w_pop     = o_q_valid && i_q_ready;
    assign o_q_item  = r_q[r_rd];

    always_comb begin
        w_item.data_byte  = i_data_byte;
        w_item.in_record  = (r_pos < i_record_len);
        w_item.pos        = r_pos;
        w_item.last_byte  = i_last_byte;
        // bytes left after this one
        w_item.room = {1'b0, i_record_len} - {1'b0, r_pos} - 9'd1;
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr] <= w_item;
        end
        if (!i_rst_n) begin
            r_pos <= '0;
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= ~r_wr;
                if (i_last_byte) begin
                    r_pos <= '0;
                end else if (r_pos != 8'hFF) begin
                    r_pos <= r_pos + 8'd1;
                end
            end
            if (w_pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'd2) else $error("queue count overflow");
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2) |-> !w_push) else $error("push into full queue");
    a_pos_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && i_last_byte) |=> (r_pos == 8'd0)) else $error("position not cleared");
endmodule

// ===== hdl/auf_walker.sv =====
// ----------------------------------------------------------------------------
// auf_walker
// One field walker: type-length or length-type order, UUID pair compare.
// ----------------------------------------------------------------------------
module auf_walker #(
    parameter bit LenFirst = 1'b0
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic       i_clear,
    input  logic [7:0] i_byte,
    input  logic [8:0] i_room,
    input  logic [15:0] i_target,
    output logic       o_hit
);
    typedef enum logic [1:0] {PH_FIRST, PH_SECOND, PH_VALUE} t_phase;

    t_phase     r_phase;
    logic [7:0] r_rem;
    logic       r_uuid;
    logic [8:0] r_pend;
    logic       r_stop;
    logic       w_bad;

    assign w_bad = (i_byte == 8'd0) || ({1'b0, i_byte} > i_room);

    always_comb begin
        o_hit = 1'b0;
        if (i_step && !r_stop && r_phase == PH_VALUE && r_uuid && r_pend[8]
            && {i_byte, r_pend[7:0]} == i_target) begin
            o_hit = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_phase <= PH_FIRST;
            r_rem   <= '0;
            r_uuid  <= 1'b0;
            r_pend  <= '0;
            r_stop  <= 1'b0;
        end else if (i_step && !r_stop) begin
            case (r_phase)
                PH_FIRST: begin
                    if (LenFirst) begin
                        if (w_bad) begin
                            r_stop <= 1'b1;
                        end else begin
                            r_rem   <= i_byte - 8'd1;
                            r_phase <= PH_SECOND;
                        end
                    end else begin
                        r_uuid  <= auf_pkg::is_uuid_type(i_byte);
                        r_phase <= PH_SECOND;
                    end
                end
                PH_SECOND: begin
                    if (LenFirst) begin
                        r_uuid  <= auf_pkg::is_uuid_type(i_byte);
                        r_pend  <= '0;
                        r_phase <= (r_rem == 8'd0) ? PH_FIRST : PH_VALUE;
                    end else if (w_bad) begin
                        r_stop <= 1'b1;
                    end else begin
                        r_rem   <= i_byte;
                        r_pend  <= '0;
                        r_phase <= PH_VALUE;
                    end
                end
                default: begin
                    if (r_uuid) begin
                        r_pend <= r_pend[8] ? 9'd0 : {1'b1, i_byte};
                    end
                    r_rem <= r_rem - 8'd1;
                    if (r_rem == 8'd1) begin
                        r_pend  <= '0;
                        r_phase <= PH_FIRST;
                    end
                end
            endcase
        end
    end

    a_stop_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_stop && !i_clear) |=> r_stop) else $error("walker restarted");
    a_value_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_VALUE) |-> (r_rem != 8'd0)) else $error("empty value phase");
    a_hit_uuid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_hit |-> r_uuid) else $error("hit outside uuid field");
endmodule

// ===== hdl/auf_back.sv =====
// ----------------------------------------------------------------------------
// auf_back
// Runs both walkers and the name window on queued items; holds one result.
// ----------------------------------------------------------------------------
module auf_back #(
    parameter int unsigned MaxNameBytes = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    output logic           o_q_ready,
    input  auf_pkg::t_item i_q_item,
    input  logic [15:0]    i_target,
    input  logic [127:0]   i_name,
    input  logic [4:0]     i_name_len,
    output logic           o_valid,
    input  logic           i_ready,
    output logic           o_uuid_found,
    output logic           o_name_found,
    output logic           o_accept
);
    localparam int unsigned LenW = $clog2(MaxNameBytes + 1);
    localparam int unsigned WinN = (MaxNameBytes < auf_pkg::NameMax) ? MaxNameBytes
                                                                      : auf_pkg::NameMax;

    logic [7:0]      r_win [MaxNameBytes];
    logic            r_uuid_flag;
    logic            r_name_flag;
    logic            r_valid;
    logic            r_res_uuid;
    logic            r_res_name;
    logic            w_take;
    logic            w_step;
    logic            w_clear;
    logic            w_hit_tl;
    logic            w_hit_lt;
    logic            w_name_hit;
    logic [LenW-1:0] w_len;
    logic [7:0]      w_win [MaxNameBytes];

    // only a last byte needs the result register free
    assign o_q_ready = !r_valid || i_ready || !i_q_item.last_byte;
    assign w_take    = i_q_valid && o_q_ready;
    assign w_step    = w_take && i_q_item.in_record;
    assign w_clear   = w_take && i_q_item.last_byte;

    auf_walker #(.LenFirst(1'b0)) u_tl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_step(w_step), .i_clear(w_clear),
        .i_byte(i_q_item.data_byte), .i_room(i_q_item.room), .i_target(i_target),
        .o_hit(w_hit_tl)
    );
    auf_walker #(.LenFirst(1'b1)) u_lt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_step(w_step), .i_clear(w_clear),
        .i_byte(i_q_item.data_byte), .i_room(i_q_item.room), .i_target(i_target),
        .o_hit(w_hit_lt)
    );

    always_comb begin
        if ({1'b0, i_name_len} > 6'(MaxNameBytes)) begin
            w_len = LenW'(MaxNameBytes);
        end else begin
            w_len = LenW'(i_name_len);
        end
        w_win[0] = i_q_item.data_byte;
        for (int k = 1; k < MaxNameBytes; k++) begin
            w_win[k] = r_win[k-1];
        end
        w_name_hit = (w_len != '0) && ({1'b0, i_q_item.pos} + 9'd1 >= 9'(w_len));
        for (int i = 0; i < MaxNameBytes; i++) begin
            if (i < int'(w_len)) begin
                if (i >= WinN) begin
                    if (w_win[int'(w_len) - 1 - i] != 8'd0) w_name_hit = 1'b0;
                end else if (w_win[int'(w_len) - 1 - i] != i_name[i*8 +: 8]) begin
                    w_name_hit = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_clear) begin
            for (int k = 0; k < MaxNameBytes; k++) begin
                r_win[k] <= '0;
            end
        end else if (w_step) begin
            for (int k = 0; k < MaxNameBytes; k++) begin
                r_win[k] <= w_win[k];
            end
        end
        if (w_clear) begin
            r_res_uuid <= r_uuid_flag || (w_step && (w_hit_tl || w_hit_lt));
            r_res_name <= r_name_flag || (w_step && w_name_hit);
        end
        if (!i_rst_n) begin
            r_uuid_flag <= 1'b0;
            r_name_flag <= 1'b0;
            r_valid     <= 1'b0;
        end else begin
            if (w_clear) begin
                r_uuid_flag <= 1'b0;
                r_name_flag <= 1'b0;
            end else if (w_step) begin
                if (w_hit_tl || w_hit_lt) r_uuid_flag <= 1'b1;
                if (w_name_hit) r_name_flag <= 1'b1;
            end
            if (w_clear) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_valid      = r_valid;
    assign o_uuid_found = r_res_uuid;
    assign o_name_found = r_res_name;
    assign o_accept     = r_res_uuid || r_res_name;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !i_ready) |=> (r_valid && $stable(r_res_uuid) && $stable(r_res_name)))
        else $error("result dropped");
    a_flags_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_clear |=> (!r_uuid_flag && !r_name_flag)) else $error("flags kept");
    a_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_clear |=> r_valid) else $error("no result");
endmodule

// ===== hdl/advert_uuid_name_filter.sv =====
// ----------------------------------------------------------------------------
// advert_uuid_name_filter
// Advertising record filter: UUID search by two field walkers, name search.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid/o_ready) carries one record byte per item with the
//   record length and a last-byte flag. One result item (o_valid/i_ready)
//   is given per record, after its last byte: uuid_found, name_found, accept.
//   Config channel (i_cfg_valid/o_cfg_ready) writes registers by index:
//   0 target UUID, 1 name bytes 0-7, 2 name bytes 8-15, 3 name length.
//   Throughput: one byte per cycle while results are taken, set by the walker
//   and name window update in the back stage.
//   After the last byte is accepted it passes the queue register, then the
//   result register, which raises o_valid; the result is held until i_ready.
//   Reset clears the position, walkers, window and queue; registers return
//   to UUID 0xABCD and an empty name.
//   A stalled receiver holds the result; bytes of the next record keep
//   flowing until its last byte reaches the back stage, then the two-entry
//   queue fills and o_ready drops.
// ----------------------------------------------------------------------------
module advert_uuid_name_filter #(
    parameter int unsigned MAX_NAME_BYTES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic [7:0]  i_record_len,
    input  logic        i_last_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_uuid_found,
    output logic        o_name_found,
    output logic        o_accept,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);
    logic [15:0]    r_target;
    logic [127:0]   r_name;
    logic [4:0]     r_name_len;
    logic           w_q_valid;
    logic           w_q_ready;
    auf_pkg::t_item w_q_item;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target   <= auf_pkg::UUID_RESET;
            r_name     <= '0;
            r_name_len <= '0;
        end else if (i_cfg_valid) begin
            case (auf_pkg::t_cfg_index'(i_cfg_index))
                auf_pkg::CFG_TARGET_UUID: r_target <= i_cfg_data[15:0];
                auf_pkg::CFG_NAME_LOW:    r_name[63:0] <= i_cfg_data;
                auf_pkg::CFG_NAME_HIGH:   r_name[127:64] <= i_cfg_data;
                auf_pkg::CFG_NAME_LENGTH: r_name_len <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    auf_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_data_byte(i_data_byte), .i_record_len(i_record_len),
        .i_last_byte(i_last_byte), .o_q_valid(w_q_valid), .i_q_ready(w_q_ready),
        .o_q_item(w_q_item)
    );

    auf_back #(.MaxNameBytes(MAX_NAME_BYTES)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_q_valid(w_q_valid),
        .o_q_ready(w_q_ready), .i_q_item(w_q_item), .i_target(r_target),
        .i_name(r_name), .i_name_len(r_name_len), .o_valid(o_valid),
        .i_ready(i_ready), .o_uuid_found(o_uuid_found),
        .o_name_found(o_name_found), .o_accept(o_accept)
    );

    a_accept_or: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_accept == (o_uuid_found || o_name_found)))
        else $error("accept mismatch");
    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready) else $error("config stalled");
    a_reset_uuid: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_target == auf_pkg::UUID_RESET)) else $error("uuid reset");
endmodule
